// ===== rtl/e2r_pkg.sv =====
// Package: constants, types and helpers for the Euler-angle to rotation-matrix core.
package e2r_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int N_STEPS = (CORDIC_ITERATIONS < ATAN_ENTRIES) ? CORDIC_ITERATIONS
                                                                : ATAN_ENTRIES;
    localparam int CW = 34;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [15:0]   UNIT_Q14    = 16'sd16384;

    typedef logic signed [15:0]  t_q14;
    typedef logic signed [47:0]  t_q42;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 neg;
    } t_cordic;

    typedef struct packed {
        t_q14 s_p;
        t_q14 c_p;
        t_q14 s_t;
        t_q14 c_t;
        t_q14 s_f;
        t_q14 c_f;
    } t_trig;

    function automatic logic signed [CW-1:0] atan_val(input int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'h3243F6A8;  1: a = 32'h1DAC6705;  2: a = 32'h0FADBAFC;
            3:  a = 32'h07F56EA6;  4: a = 32'h03FEAB76;  5: a = 32'h01FFD55B;
            6:  a = 32'h00FFFAAA;  7: a = 32'h007FFF55;  8: a = 32'h003FFFEA;
            9:  a = 32'h001FFFFD; 10: a = 32'h000FFFFF; 11: a = 32'h0007FFFF;
            12: a = 32'h0003FFFF; 13: a = 32'h0001FFFF; 14: a = 32'h0000FFFF;
            15: a = 32'h00007FFF; 16: a = 32'h00003FFF; 17: a = 32'h00001FFF;
            18: a = 32'h00000FFF; 19: a = 32'h000007FF; 20: a = 32'h000003FF;
            21: a = 32'h000001FF; 22: a = 32'h000000FF; 23: a = 32'h0000007F;
            default: a = 32'h0;
        endcase
        return $signed({2'b00, a});
    endfunction

    function automatic t_q14 round_q30(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + 34'sd32768) >>> 16;
        if (r > 34'sd16384)       return UNIT_Q14;
        else if (r < -34'sd16384) return -UNIT_Q14;
        else                      return r[15:0];
    endfunction

    function automatic t_q14 round_q42(input t_q42 v);
        t_q42 r;
        r = (v + 48'sd134217728) >>> 28;
        if (r > 48'sd16384)       return UNIT_Q14;
        else if (r < -48'sd16384) return -UNIT_Q14;
        else                      return r[15:0];
    endfunction

endpackage

// ===== rtl/e2r_cordic_cell.sv =====
// One CORDIC micro-rotation cell for the three angle lanes.
module e2r_cordic_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [4:0]      i_step,
    input  logic            i_vld,
    input  e2r_pkg::t_cordic i_d [3],
    output logic            o_vld,
    output e2r_pkg::t_cordic o_d [3]
);
    import e2r_pkg::*;

    t_cordic n_d [3];
    t_cordic r_d [3];
    logic    r_vld;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_d[k] = i_d[k];
            if (!i_d[k].z[CW-1]) begin
                n_d[k].x = i_d[k].x - (i_d[k].y >>> i_step);
                n_d[k].y = i_d[k].y + (i_d[k].x >>> i_step);
                n_d[k].z = i_d[k].z - atan_val(int'(i_step));
            end else begin
                n_d[k].x = i_d[k].x + (i_d[k].y >>> i_step);
                n_d[k].y = i_d[k].y - (i_d[k].x >>> i_step);
                n_d[k].z = i_d[k].z + atan_val(int'(i_step));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
        if (!i_rst_n) r_vld <= 1'b0;
        else          r_vld <= i_vld;
    end

    assign o_d   = r_d;
    assign o_vld = r_vld;
endmodule

// ===== rtl/e2r_matrix.sv =====
// Matrix product stages: trig terms to nine saturated Q1.14 entries.
module e2r_matrix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  e2r_pkg::t_trig i_t,
    output logic          o_vld,
    output e2r_pkg::t_q14 o_m [9]
);
    import e2r_pkg::*;

    logic signed [31:0] r_p [8];
    t_trig              r_t;
    t_q42               r_s [9];
    t_q14               r_m [9];
    logic [2:0]         r_vld;

    always_ff @(posedge i_clk) begin
        r_t    <= i_t;
        r_p[0] <= i_t.c_t * i_t.c_p;
        r_p[1] <= i_t.c_f * i_t.s_p;
        r_p[2] <= i_t.s_f * i_t.s_t;
        r_p[3] <= i_t.s_f * i_t.s_p;
        r_p[4] <= i_t.c_f * i_t.s_t;
        r_p[5] <= i_t.c_t * i_t.s_p;
        r_p[6] <= i_t.c_f * i_t.c_p;
        r_p[7] <= i_t.s_f * i_t.c_p;

        r_s[0] <= {{2{r_p[0][31]}}, r_p[0], 14'd0};
        r_s[1] <= {{2{r_p[1][31]}}, r_p[1], 14'd0} + 48'(r_p[2] * r_t.c_p);
        r_s[2] <= {{2{r_p[3][31]}}, r_p[3], 14'd0} - 48'(r_p[4] * r_t.c_p);
        r_s[3] <= -{{2{r_p[5][31]}}, r_p[5], 14'd0};
        r_s[4] <= {{2{r_p[6][31]}}, r_p[6], 14'd0} - 48'(r_p[2] * r_t.s_p);
        r_s[5] <= {{2{r_p[7][31]}}, r_p[7], 14'd0} + 48'(r_p[4] * r_t.s_p);
        r_s[6] <= {{4{r_t.s_t[15]}}, r_t.s_t, 28'd0};
        r_s[7] <= -48'(48'(r_t.s_f * r_t.c_t) <<< 14);
        r_s[8] <= 48'(48'(r_t.c_f * r_t.c_t) <<< 14);

        for (int k = 0; k < 9; k++) r_m[k] <= round_q42(r_s[k]);

        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[1:0], i_vld};
    end

    assign o_m   = r_m;
    assign o_vld = r_vld[2];
endmodule

// ===== rtl/euler_to_rotation_matrix_core.sv =====
// Top level: folding, CORDIC cell chain and matrix stages for Euler angles.
//
//  channel | direction | signals
//  angles  | in / out  | start, i_psi_angle, i_theta_angle, i_phi_angle in; busy out
//  matrix  | out       | o_done, o_r_xx .. o_r_zz
//
// One angle triple per cycle; the pipeline registers are, in order: fold,
// one cell per CORDIC step, trig rounding, three matrix stages.
// busy is held low: the pipeline never stalls. Results are shown for one
// cycle with o_done. Synchronous reset clears the valid chain only.
module euler_to_rotation_matrix_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_psi_angle,
    input  logic [15:0] i_theta_angle,
    input  logic [15:0] i_phi_angle,
    output logic        o_done,
    output logic [15:0] o_r_xx,
    output logic [15:0] o_r_xy,
    output logic [15:0] o_r_xz,
    output logic [15:0] o_r_yx,
    output logic [15:0] o_r_yy,
    output logic [15:0] o_r_yz,
    output logic [15:0] o_r_zx,
    output logic [15:0] o_r_zy,
    output logic [15:0] o_r_zz
);
    import e2r_pkg::*;

    t_cordic r_fold [3];
    logic    r_fvld;
    t_cordic c_d [N_STEPS+1][3];
    logic    c_v [N_STEPS+1];
    t_trig   r_trig;
    logic    r_tvld;
    t_q14    m [9];
    logic    m_vld;
    logic [15:0] ang [3];

    assign busy   = 1'b0;
    assign ang[0] = i_psi_angle;
    assign ang[1] = i_theta_angle;
    assign ang[2] = i_phi_angle;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            logic signed [CW-1:0] z;
            z = {{(CW-33){ang[k][15]}}, ang[k], 17'd0};
            r_fold[k].x   <= CORDIC_GAIN;
            r_fold[k].y   <= '0;
            r_fold[k].neg <= (z > HALF_PI_Q30) || (z < -HALF_PI_Q30);
            if (z > HALF_PI_Q30)       r_fold[k].z <= z - PI_Q30;
            else if (z < -HALF_PI_Q30) r_fold[k].z <= z + PI_Q30;
            else                       r_fold[k].z <= z;
        end
        if (!i_rst_n) r_fvld <= 1'b0;
        else          r_fvld <= start;
    end

    assign c_d[0] = r_fold;
    assign c_v[0] = r_fvld;

    for (genvar g = 0; g < N_STEPS; g++) begin : g_cell
        e2r_cordic_cell u_cell (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_step (5'(g)),
            .i_vld (c_v[g]), .i_d (c_d[g]),
            .o_vld (c_v[g+1]), .o_d (c_d[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        t_q14 s [3];
        t_q14 c [3];
        for (int k = 0; k < 3; k++) begin
            if (c_d[N_STEPS][k].neg) begin
                s[k] = round_q30(-c_d[N_STEPS][k].y);
                c[k] = round_q30(-c_d[N_STEPS][k].x);
            end else begin
                s[k] = round_q30(c_d[N_STEPS][k].y);
                c[k] = round_q30(c_d[N_STEPS][k].x);
            end
        end
        r_trig <= '{s_p: s[0], c_p: c[0], s_t: s[1], c_t: c[1], s_f: s[2], c_f: c[2]};
        if (!i_rst_n) r_tvld <= 1'b0;
        else          r_tvld <= c_v[N_STEPS];
    end

    e2r_matrix u_matrix (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_vld (r_tvld), .i_t (r_trig),
        .o_vld (m_vld), .o_m (m)
    );

    assign o_done = m_vld;
    assign o_r_xx = m[0];
    assign o_r_xy = m[1];
    assign o_r_xz = m[2];
    assign o_r_yx = m[3];
    assign o_r_yy = m[4];
    assign o_r_yz = m[5];
    assign o_r_zx = m[6];
    assign o_r_zy = m[7];
    assign o_r_zz = m[8];

    a_zx_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($signed(o_r_zx) <= 16'sd16384 && $signed(o_r_zx) >= -16'sd16384))
        else $error("r_zx out of range");
    a_zz_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($signed(o_r_zz) <= 16'sd16384 && $signed(o_r_zz) >= -16'sd16384))
        else $error("r_zz out of range");
    a_trig_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tvld |-> ##3 o_done)
        else $error("matrix stage lost a transaction");
endmodule

// ===== bench/tb_euler_to_rotation_matrix_core.sv =====
// Testbench: Euler-angle to rotation-matrix core against a bit-exact fixed-point predictor.
`timescale 1ns / 100ps

module tb_euler_to_rotation_matrix_core;
    import e2r_pkg::*;

    localparam int LATENCY = N_STEPS + 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM = 600;
    localparam int N_DIRECTED = 14;
    localparam logic [15:0] NO_CHECK = 16'hFFFF;

    typedef struct packed {
        logic [15:0] xx, xy, xz, yx, yy, yz, zx, zy, zz;
    } t_matrix;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [15:0] i_psi_angle = '0, i_theta_angle = '0, i_phi_angle = '0;
    logic        busy, o_done;
    logic [15:0] o_r_xx, o_r_xy, o_r_xz, o_r_yx, o_r_yy, o_r_yz, o_r_zx, o_r_zy, o_r_zz;

    t_matrix matrix_queue[$];
    t_matrix fixed_queue[$];
    int      error_count = 0;
    int      idle_cycles = 0;
    bit      gaps_on = 1'b1;

    euler_to_rotation_matrix_core dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic signed [63:0] shr(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] unit_clamp(input logic signed [63:0] v);
        if (v > 64'sd16384) return 64'sd16384;
        if (v < -64'sd16384) return -64'sd16384;
        return v;
    endfunction

    function automatic void trig_of(input logic [15:0] raw,
                                    output logic signed [63:0] s, output logic signed [63:0] c);
        logic signed [63:0] x, y, z, dx, dy, a;
        logic [31:0] tab [24];
        bit neg;
        tab = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
                32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
                32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
                32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
                32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F};
        z = 64'($signed(raw)) * 64'sd131072;
        x = 64'sd652032874;
        y = 0;
        neg = 1'b0;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426; neg = 1'b1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426; neg = 1'b1;
        end
        for (int i = 0; i < N_STEPS; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            a = $signed({32'h0, tab[i]});
            if (z >= 0) begin
                x -= dx; y += dy; z -= a;
            end else begin
                x += dx; y -= dy; z += a;
            end
        end
        if (neg) begin
            x = -x; y = -y;
        end
        s = unit_clamp(shr(y + 32768, 16));
        c = unit_clamp(shr(x + 32768, 16));
    endfunction

    function automatic logic [15:0] to_q14(input logic signed [63:0] q42);
        logic signed [63:0] v;
        v = unit_clamp(shr(q42 + 64'sd134217728, 28));
        return v[15:0];
    endfunction

    function automatic t_matrix rotation_of(input logic [15:0] p, input logic [15:0] t,
                                            input logic [15:0] f);
        logic signed [63:0] sp, cp, st, ct, sf, cf;
        t_matrix m;
        trig_of(p, sp, cp);
        trig_of(t, st, ct);
        trig_of(f, sf, cf);
        m.xx = to_q14(ct * cp * 16384);
        m.xy = to_q14(cf * sp * 16384 + sf * st * cp);
        m.xz = to_q14(sf * sp * 16384 - cf * st * cp);
        m.yx = to_q14(-(ct * sp * 16384));
        m.yy = to_q14(cf * cp * 16384 - sf * st * sp);
        m.yz = to_q14(sf * cp * 16384 + cf * st * sp);
        m.zx = to_q14(st * 16384 * 16384);
        m.zy = to_q14(-(sf * ct * 16384));
        m.zz = to_q14(cf * ct * 16384);
        return m;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what,
                 $signed(got), $signed(want), $time);
        error_count++;
    endtask

    task automatic compare_field(input string what, input logic [15:0] got,
                                 input logic [15:0] want, input logic [15:0] fixed);
        if (got !== want) report_mismatch(what, got, want);
        if (fixed !== NO_CHECK && got !== fixed) report_mismatch({what, " (table)"}, got, fixed);
    endtask

    always @(posedge i_clk) begin
        t_matrix m, f;
        if (i_rst_n) begin
            if ((start && !busy) || o_done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_done) begin
                if (matrix_queue.size() == 0) begin
                    $display("unexpected matrix transaction at %0t", $time);
                    error_count++;
                end else begin
                    m = matrix_queue.pop_front();
                    f = fixed_queue.pop_front();
                    compare_field("r_xx", o_r_xx, m.xx, f.xx);
                    compare_field("r_xy", o_r_xy, m.xy, f.xy);
                    compare_field("r_xz", o_r_xz, m.xz, f.xz);
                    compare_field("r_yx", o_r_yx, m.yx, f.yx);
                    compare_field("r_yy", o_r_yy, m.yy, f.yy);
                    compare_field("r_yz", o_r_yz, m.yz, f.yz);
                    compare_field("r_zx", o_r_zx, m.zx, f.zx);
                    compare_field("r_zy", o_r_zy, m.zy, f.zy);
                    compare_field("r_zz", o_r_zz, m.zz, f.zz);
                end
            end
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("FAIL euler_to_rotation_matrix_core");
                $finish;
            end
        end
    end

    // Drives one angle transaction; start stays high across back-to-back items.
    task automatic send_angles(input logic [15:0] p, input logic [15:0] t,
                               input logic [15:0] f, input t_matrix fixed);
        int gap;
        if (gaps_on && $urandom_range(3) == 0) begin
            gap = $urandom_range(4, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_psi_angle <= p;
        i_theta_angle <= t;
        i_phi_angle <= f;
        matrix_queue.push_back(rotation_of(p, t, f));
        fixed_queue.push_back(fixed);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [15:0] random_angle();
        case ($urandom_range(9))
            0: return 16'($urandom());
            1: return 16'($signed($urandom_range(400)) - 200);
            default: return 16'($signed($urandom_range(51472)) - 25736);
        endcase
    endfunction

    logic [15:0] dir_angles [N_DIRECTED][3];
    t_matrix     dir_fixed [N_DIRECTED];

    initial begin
        t_matrix free_row;
        t_matrix identity;
        free_row = {9{NO_CHECK}};
        identity = {16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384};
        dir_angles = '{
            '{16'd0, 16'd0, 16'd0},
            '{16'd25736, 16'd0, 16'd0},
            '{-16'sd25736, 16'd0, 16'd0},
            '{16'd0, 16'd25736, 16'd0},
            '{16'd0, 16'd0, -16'sd25736},
            '{16'd12868, 16'd12868, 16'd12868},
            '{-16'sd12868, -16'sd12868, -16'sd12868},
            '{16'd12869, 16'd12867, -16'sd12869},
            '{16'h7FFF, 16'h8000, 16'h7FFF},
            '{16'h8000, 16'h7FFF, 16'h8000},
            '{16'hFFFF, 16'h0001, 16'hFFFF},
            '{16'hAAAA, 16'h5555, 16'hAAAA},
            '{16'h5555, 16'hAAAA, 16'h5555},
            '{16'd6434, -16'sd6434, 16'd19302}
        };
        foreach (dir_fixed[k]) dir_fixed[k] = free_row;
        dir_fixed[0] = identity;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++)
            send_angles(dir_angles[k][0], dir_angles[k][1], dir_angles[k][2], dir_fixed[k]);
        start <= 1'b0;
        while (matrix_queue.size() != 0) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 100) gaps_on = 1'b0;
            send_angles(random_angle(), random_angle(), random_angle(), free_row);
        end
        start <= 1'b0;

        while (matrix_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (error_count == 0) $display("PASS euler_to_rotation_matrix_core");
        else $display("FAIL euler_to_rotation_matrix_core");
        $finish;
    end
endmodule
